### rtl/apne_pkg.sv
package apne_pkg;

    // default sizes
    localparam int DIM_DEF        = 4;
    localparam int MAX_WINDOW_DEF = 16;

    // fixed field widths
    localparam int VAL_W       = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int FUNC_W      = 3;
    localparam int STAT_W      = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 17;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 32;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // function codes
    localparam logic [FUNC_W-1:0] F_DX     = 3'd0;
    localparam logic [FUNC_W-1:0] F_POST   = 3'd1;
    localparam logic [FUNC_W-1:0] F_TRANS  = 3'd2;
    localparam logic [FUNC_W-1:0] F_COMMIT = 3'd3;
    localparam logic [FUNC_W-1:0] F_QUERY  = 3'd4;
    localparam logic [FUNC_W-1:0] F_WRESET = 3'd5;
    localparam logic [FUNC_W-1:0] F_INIT   = 3'd6;
    localparam logic [FUNC_W-1:0] F_OFFSET = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_DT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 4'd3;

    // banks of the matrix memory
    localparam int          BANKS      = 8;
    localparam logic [2:0]  BANK_DX    = 3'd0;
    localparam logic [2:0]  BANK_SPOST = 3'd1;
    localparam logic [2:0]  BANK_TRANS = 3'd2;
    localparam logic [2:0]  BANK_CUR   = 3'd3;
    localparam logic [2:0]  BANK_PROP  = 3'd4;
    localparam logic [2:0]  BANK_INIT  = 3'd5;
    localparam logic [2:0]  BANK_OFF   = 3'd6;
    localparam logic [2:0]  BANK_TMP   = 3'd7;

    // divider control and response
    typedef struct packed {
        logic start;
        logic floor_mode;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

### rtl/apne_div.sv
module apne_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  apne_pkg::div_req_t               req,
    input  logic signed [apne_pkg::NUM_W-1:0] num,
    input  logic signed [apne_pkg::DEN_W-1:0] den,
    output apne_pkg::div_rsp_t               rsp
);

    localparam int NW = apne_pkg::NUM_W;
    localparam int DW = apne_pkg::DEN_W;
    localparam int CNW = $clog2(NW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [NW-1:0]  quo_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  dmag_reg;
    logic           neg_reg;
    logic           flr_reg;

    logic [NW-1:0]  num_mag;
    logic [DW-1:0]  den_mag;
    logic [DW:0]    trial;
    logic           fits;
    logic [NW-1:0]  res_mag;

    // magnitudes of the operands
    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

    // one restoring step
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = (trial >= {1'b0, dmag_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg  <= num_mag;
            rem_reg  <= '0;
            dmag_reg <= den_mag;
            neg_reg  <= num[NW-1] ^ den[DW-1];
            flr_reg  <= req.floor_mode;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(trial - {1'b0, dmag_reg}) : DW'(trial);
        end
    end

    // signed result, truncated or floored
    assign res_mag = (neg_reg && flr_reg && (rem_reg != '0)) ? quo_reg + 1'b1 : quo_reg;

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? -$signed(res_mag) : $signed(res_mag);

endmodule

### rtl/adaptive_process_noise_estimator_top.sv
// Adaptive process-noise estimator. Items arrive on the s_ stream with a function code in
// s_tuser; every item gives exactly one result beat on the m_ stream. After reset the block
// initialises its matrix memory and takes no item meanwhile; configuration writes are taken
// at any time. Loads and window resets go from decode straight to the result beat. A query
// walks the n window entries in use, newest first, and then blends on the radix-2 divider.
// A commit computes the DIM*DIM outer products (each one shared 32x32 multiply plus a
// division), the two matrix products on the same shared multiplier and the posterior copy.
// A commit with zero dt goes from decode straight to the result beat. A stalled result
// beat holds the block until it is taken.
module adaptive_process_noise_estimator_top
#(
    parameter int DIM        = apne_pkg::DIM_DEF,
    parameter int MAX_WINDOW = apne_pkg::MAX_WINDOW_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [apne_pkg::IN_TDATA_W-1:0]      s_tdata,  // row[1:0], col[3:2], value[35:4]
    input  logic [apne_pkg::FUNC_W-1:0]          s_tuser,  // func[2:0]
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [apne_pkg::VAL_W-1:0]           m_tdata,  // q_entry[31:0]
    output logic [apne_pkg::STAT_W-1:0]          m_tuser,  // status[1:0]
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [apne_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [apne_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IW        = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int SW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW        = $clog2(MAX_WINDOW + 1);
    localparam int MAT_DEPTH = apne_pkg::BANKS * DIM * DIM;
    localparam int AW        = $clog2(MAT_DEPTH);
    localparam int WIN_DEPTH = MAX_WINDOW * DIM * DIM;
    localparam int WAW       = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int ACC_W     = 48;
    localparam int SUM_W     = 52;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_EXEC,
        S_Q_RD, S_Q_MW, S_Q_ACC, S_Q_WUP, S_Q_S0, S_Q_S1, S_Q_S2, S_Q_BL, S_Q_DIV, S_Q_DW,
        S_C_DRD, S_C_DMUL, S_C_DIV, S_C_DW,
        S_M_RD, S_M_MUL, S_M_ACC, S_CP_RD, S_CP_WR,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [4:0]  wl_reg;
    logic        diag_reg;
    logic [16:0] decay_reg;
    logic [16:0] scale_reg;

    // item
    logic [apne_pkg::FUNC_W-1:0] func_reg;
    logic [1:0]                  row_reg;
    logic [1:0]                  col_reg;
    logic signed [31:0]          val_reg;

    // sequencer state
    logic [2:0]    bank_reg;
    logic [IW-1:0] rr_reg;
    logic [IW-1:0] cc_reg;
    logic [IW-1:0] kk_reg;
    logic          phase_reg;
    logic          sat_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] head_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [16:0]   w_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] adapt_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic signed [63:0]      q_num_reg;
    logic [31:0]             res_q_reg;
    logic [apne_pkg::STAT_W-1:0] res_st_reg;

    // output beat
    logic                        m_tvalid_reg;
    logic [31:0]                 m_tdata_reg;
    logic [apne_pkg::STAT_W-1:0] m_tuser_reg;

    // memories
    logic signed [31:0] mat_mem [MAT_DEPTH];
    logic signed [31:0] win_mem [WIN_DEPTH];
    logic signed [31:0] rd0_reg;
    logic signed [31:0] rd1_reg;
    logic signed [31:0] win_rd_reg;
    logic [AW-1:0]      ra0;
    logic [AW-1:0]      ra1;
    logic               mw_en;
    logic [AW-1:0]      mw_addr;
    logic signed [31:0] mw_data;
    logic               ww_en;
    logic [WAW-1:0]     ww_addr;
    logic [WAW-1:0]     wr_addr;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p_reg;

    // divider
    apne_pkg::div_req_t  div_req;
    apne_pkg::div_rsp_t  div_rsp;
    logic signed [63:0]  div_num;
    logic signed [31:0]  div_den;

    // derived values
    logic [CW-1:0]           l_eff;
    logic [CW-1:0]           n_eff;
    logic                    row_ok;
    logic                    item_ok;
    logic signed [SUM_W-1:0] s_next;
    logic signed [63:0]      rnd_p;
    logic signed [63:0]      blend;
    logic                    rr_last;
    logic                    cc_last;
    logic                    kk_last;
    logic [31:0]             win_q;
    logic                    win_q_sat;

    function automatic logic [AW-1:0] mat_addr(input logic [2:0] b,
                                               input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
        return AW'(b * DIM * DIM + r * DIM + c);
    endfunction

    function automatic logic [WAW-1:0] win_addr(input logic [SW-1:0] s,
                                                input logic [IW-1:0] r,
                                                input logic [IW-1:0] c);
        return WAW'(s * DIM * DIM + r * DIM + c);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic is_sat(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    // round half up of a Q32.32 product back to Q16.16
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

    // effective window length and used entry count
    always_comb
    begin
        if (wl_reg == 5'd0)
            l_eff = CW'(1);
        else if (32'(wl_reg) > MAX_WINDOW)
            l_eff = CW'(MAX_WINDOW);
        else
            l_eff = CW'(wl_reg);
        n_eff = (count_reg < l_eff) ? count_reg : l_eff;
    end

    assign row_ok  = (32'(row_reg) < DIM);
    assign item_ok = row_ok && (32'(col_reg) < DIM);
    assign rr_last = (rr_reg == IW'(DIM - 1));
    assign cc_last = (cc_reg == IW'(DIM - 1));
    assign kk_last = (kk_reg == IW'(DIM - 1));

    assign rnd_p  = rnd16(mul_p_reg);
    assign s_next = s_reg + SUM_W'(rnd_p);
    assign blend  = (64'(adapt_reg) * $signed({1'b0, n_reg}) + mul_p_reg) * 64'sd2
                    + $signed(64'(l_eff));
    assign win_q     = sat32(div_rsp.quot);
    assign win_q_sat = is_sat(div_rsp.quot);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_Q_MW:
            begin
                mul_a = $signed({15'd0, w_reg});
                mul_b = win_rd_reg;
            end
            S_Q_ACC:
            begin
                mul_a = $signed({15'd0, w_reg});
                mul_b = $signed({15'd0, decay_reg});
            end
            S_Q_S2:
            begin
                mul_a = rd1_reg;
                mul_b = $signed(32'(l_eff - n_reg));
            end
            S_C_DMUL, S_M_MUL:
            begin
                mul_a = rd0_reg;
                mul_b = rd1_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // matrix memory read addresses
    always_comb
    begin
        ra0 = '0;
        ra1 = '0;
        unique case (state_reg)
            S_Q_S0:
            begin
                ra0 = mat_addr(apne_pkg::BANK_CUR, rr_reg, cc_reg);
                ra1 = mat_addr(apne_pkg::BANK_PROP, rr_reg, cc_reg);
            end
            S_Q_S1:
            begin
                ra0 = mat_addr(apne_pkg::BANK_OFF, rr_reg, cc_reg);
                ra1 = mat_addr(apne_pkg::BANK_INIT, rr_reg, cc_reg);
            end
            S_C_DRD:
            begin
                ra0 = mat_addr(apne_pkg::BANK_DX, rr_reg, '0);
                ra1 = mat_addr(apne_pkg::BANK_DX, cc_reg, '0);
            end
            S_M_RD:
            begin
                if (!phase_reg)
                begin
                    ra0 = mat_addr(apne_pkg::BANK_TRANS, rr_reg, kk_reg);
                    ra1 = mat_addr(apne_pkg::BANK_CUR, kk_reg, cc_reg);
                end
                else
                begin
                    ra0 = mat_addr(apne_pkg::BANK_TMP, rr_reg, kk_reg);
                    ra1 = mat_addr(apne_pkg::BANK_TRANS, cc_reg, kk_reg);
                end
            end
            S_CP_RD:
            begin
                ra0 = mat_addr(apne_pkg::BANK_SPOST, rr_reg, cc_reg);
            end
            default:
            begin
                ra0 = '0;
                ra1 = '0;
            end
        endcase
    end

    // matrix memory write port
    always_comb
    begin
        mw_en   = 1'b0;
        mw_addr = '0;
        mw_data = '0;
        unique case (state_reg)
            S_CLR:
            begin
                mw_en   = 1'b1;
                mw_addr = mat_addr(bank_reg, rr_reg, cc_reg);
                mw_data = ((bank_reg == apne_pkg::BANK_INIT) && (rr_reg == cc_reg))
                          ? $signed(32'(apne_pkg::ONE_Q16)) : '0;
            end
            S_EXEC:
            begin
                mw_data = val_reg;
                unique case (func_reg)
                    apne_pkg::F_DX:
                    begin
                        mw_en   = row_ok;
                        mw_addr = mat_addr(apne_pkg::BANK_DX, IW'(row_reg), '0);
                    end
                    apne_pkg::F_POST:
                    begin
                        mw_en   = item_ok;
                        mw_addr = mat_addr(apne_pkg::BANK_SPOST, IW'(row_reg), IW'(col_reg));
                    end
                    apne_pkg::F_TRANS:
                    begin
                        mw_en   = item_ok;
                        mw_addr = mat_addr(apne_pkg::BANK_TRANS, IW'(row_reg), IW'(col_reg));
                    end
                    apne_pkg::F_INIT:
                    begin
                        mw_en   = item_ok;
                        mw_addr = mat_addr(apne_pkg::BANK_INIT, IW'(row_reg), IW'(col_reg));
                    end
                    apne_pkg::F_OFFSET:
                    begin
                        mw_en   = item_ok;
                        mw_addr = mat_addr(apne_pkg::BANK_OFF, IW'(row_reg), IW'(col_reg));
                    end
                    default:
                    begin
                        mw_en = 1'b0;
                    end
                endcase
            end
            S_M_ACC:
            begin
                mw_en   = kk_last;
                mw_addr = mat_addr(phase_reg ? apne_pkg::BANK_PROP : apne_pkg::BANK_TMP,
                                   rr_reg, cc_reg);
                mw_data = $signed(sat32(64'(s_next)));
            end
            S_CP_WR:
            begin
                mw_en   = 1'b1;
                mw_addr = mat_addr(apne_pkg::BANK_CUR, rr_reg, cc_reg);
                mw_data = rd0_reg;
            end
            default:
            begin
                mw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
            mat_mem[mw_addr] <= mw_data;
        rd0_reg <= mat_mem[ra0];
        rd1_reg <= mat_mem[ra1];
    end

    // window memory
    assign ww_en   = (state_reg == S_C_DW) && div_rsp.done;
    assign ww_addr = win_addr(head_reg, rr_reg, cc_reg);
    assign wr_addr = win_addr(slot_reg, rr_reg, cc_reg);

    always_ff @(posedge clk)
    begin
        if (ww_en)
            win_mem[ww_addr] <= $signed(win_q);
        win_rd_reg <= win_mem[wr_addr];
    end

    // divider operands
    assign div_req.start      = (state_reg == S_C_DIV) || (state_reg == S_Q_DIV);
    assign div_req.floor_mode = (state_reg == S_Q_DIV);
    assign div_num = (state_reg == S_C_DIV) ? mul_p_reg : q_num_reg;
    assign div_den = (state_reg == S_C_DIV) ? val_reg : $signed(32'({l_eff, 1'b0}));

    apne_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            bank_reg     <= '0;
            rr_reg       <= '0;
            cc_reg       <= '0;
            kk_reg       <= '0;
            phase_reg    <= 1'b0;
            sat_reg      <= 1'b0;
            count_reg    <= '0;
            head_reg     <= '0;
            wl_reg       <= 5'd16;
            diag_reg     <= 1'b1;
            decay_reg    <= apne_pkg::ONE_Q16;
            scale_reg    <= 17'd4096;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    apne_pkg::CFG_WLEN:  wl_reg   <= cfg_data[4:0];
                    apne_pkg::CFG_DIAG:  diag_reg <= cfg_data[0];
                    apne_pkg::CFG_DECAY: decay_reg <= (cfg_data > apne_pkg::ONE_Q16)
                                                      ? apne_pkg::ONE_Q16 : cfg_data;
                    apne_pkg::CFG_SCALE: scale_reg <= (cfg_data > apne_pkg::ONE_Q16)
                                                      ? apne_pkg::ONE_Q16 : cfg_data;
                    default: ;
                endcase
            end

            // result beat taken, unless a new one is loaded below
            if (m_tready && (state_reg != S_DONE))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                // memory initialisation sweep
                S_CLR:
                begin
                    if (cc_last)
                    begin
                        cc_reg <= '0;
                        if (rr_last)
                        begin
                            rr_reg   <= '0;
                            bank_reg <= bank_reg + 1'b1;
                            if (bank_reg == apne_pkg::BANK_TMP)
                                state_reg <= S_IDLE;
                        end
                        else
                        begin
                            rr_reg <= rr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cc_reg <= cc_reg + 1'b1;
                    end
                end

                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg  <= s_tuser;
                        row_reg   <= s_tdata[1:0];
                        col_reg   <= s_tdata[3:2];
                        val_reg   <= $signed(s_tdata[35:4]);
                        state_reg <= S_EXEC;
                    end
                end

                // decode
                S_EXEC:
                begin
                    res_q_reg <= '0;
                    sat_reg   <= 1'b0;
                    unique case (func_reg)
                        apne_pkg::F_COMMIT:
                        begin
                            if (val_reg == '0)
                            begin
                                res_st_reg <= apne_pkg::STAT_ZERO_DT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                res_st_reg <= apne_pkg::STAT_OK;
                                rr_reg     <= '0;
                                cc_reg     <= '0;
                                state_reg  <= S_C_DRD;
                            end
                        end
                        apne_pkg::F_QUERY:
                        begin
                            res_st_reg <= apne_pkg::STAT_OK;
                            if (item_ok)
                            begin
                                rr_reg    <= IW'(row_reg);
                                cc_reg    <= IW'(col_reg);
                                n_reg     <= n_eff;
                                i_reg     <= '0;
                                w_reg     <= scale_reg;
                                acc_reg   <= '0;
                                slot_reg  <= (head_reg == '0) ? SW'(MAX_WINDOW - 1)
                                                              : head_reg - 1'b1;
                                state_reg <= (n_eff == '0) ? S_Q_S0 : S_Q_RD;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        apne_pkg::F_WRESET:
                        begin
                            res_st_reg <= apne_pkg::STAT_OK;
                            count_reg  <= '0;
                            head_reg   <= '0;
                            state_reg  <= S_DONE;
                        end
                        default:
                        begin
                            res_st_reg <= apne_pkg::STAT_OK;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end

                // weighted window sum, newest entry first
                S_Q_RD:  state_reg <= S_Q_MW;
                S_Q_MW:  state_reg <= S_Q_ACC;
                S_Q_ACC:
                begin
                    acc_reg   <= acc_reg + ACC_W'(rnd_p);
                    state_reg <= S_Q_WUP;
                end
                S_Q_WUP:
                begin
                    w_reg    <= rnd_p[16:0];
                    i_reg    <= i_reg + 1'b1;
                    slot_reg <= (slot_reg == '0) ? SW'(MAX_WINDOW - 1) : slot_reg - 1'b1;
                    state_reg <= (i_reg + 1'b1 == n_reg) ? S_Q_S0 : S_Q_RD;
                end

                // add posterior terms and offset, then blend
                S_Q_S0:  state_reg <= S_Q_S1;
                S_Q_S1:
                begin
                    acc_reg   <= acc_reg + ACC_W'(rd0_reg) + ACC_W'(rd1_reg);
                    state_reg <= S_Q_S2;
                end
                S_Q_S2:
                begin
                    adapt_reg <= (diag_reg && (row_reg != col_reg)) ? '0
                                 : acc_reg + ACC_W'(rd0_reg);
                    state_reg <= S_Q_BL;
                end
                S_Q_BL:
                begin
                    q_num_reg <= blend;
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV: state_reg <= S_Q_DW;
                S_Q_DW:
                begin
                    if (div_rsp.done)
                    begin
                        res_q_reg  <= win_q;
                        res_st_reg <= win_q_sat ? apne_pkg::STAT_SAT : apne_pkg::STAT_OK;
                        state_reg  <= S_DONE;
                    end
                end

                // outer product divided by dt into the window
                S_C_DRD:  state_reg <= S_C_DMUL;
                S_C_DMUL: state_reg <= S_C_DIV;
                S_C_DIV:  state_reg <= S_C_DW;
                S_C_DW:
                begin
                    if (div_rsp.done)
                    begin
                        sat_reg <= sat_reg | win_q_sat;
                        if (cc_last)
                        begin
                            cc_reg <= '0;
                            if (rr_last)
                            begin
                                rr_reg    <= '0;
                                kk_reg    <= '0;
                                s_reg     <= '0;
                                phase_reg <= 1'b0;
                                head_reg  <= (head_reg == SW'(MAX_WINDOW - 1)) ? '0
                                             : head_reg + 1'b1;
                                count_reg <= (count_reg + 1'b1 > l_eff) ? l_eff
                                             : count_reg + 1'b1;
                                state_reg <= S_M_RD;
                            end
                            else
                            begin
                                rr_reg    <= rr_reg + 1'b1;
                                state_reg <= S_C_DRD;
                            end
                        end
                        else
                        begin
                            cc_reg    <= cc_reg + 1'b1;
                            state_reg <= S_C_DRD;
                        end
                    end
                end

                // F*P then (F*P)*F'
                S_M_RD:  state_reg <= S_M_MUL;
                S_M_MUL: state_reg <= S_M_ACC;
                S_M_ACC:
                begin
                    if (kk_last)
                    begin
                        sat_reg <= sat_reg | is_sat(64'(s_next));
                        s_reg   <= '0;
                        kk_reg  <= '0;
                        if (cc_last)
                        begin
                            cc_reg <= '0;
                            if (rr_last)
                            begin
                                rr_reg <= '0;
                                if (!phase_reg)
                                begin
                                    phase_reg <= 1'b1;
                                    state_reg <= S_M_RD;
                                end
                                else
                                begin
                                    state_reg <= S_CP_RD;
                                end
                            end
                            else
                            begin
                                rr_reg    <= rr_reg + 1'b1;
                                state_reg <= S_M_RD;
                            end
                        end
                        else
                        begin
                            cc_reg    <= cc_reg + 1'b1;
                            state_reg <= S_M_RD;
                        end
                    end
                    else
                    begin
                        s_reg     <= s_next;
                        kk_reg    <= kk_reg + 1'b1;
                        state_reg <= S_M_RD;
                    end
                end

                // staged posterior becomes current
                S_CP_RD: state_reg <= S_CP_WR;
                S_CP_WR:
                begin
                    if (cc_last)
                    begin
                        cc_reg <= '0;
                        if (rr_last)
                        begin
                            rr_reg     <= '0;
                            res_st_reg <= sat_reg ? apne_pkg::STAT_SAT : apne_pkg::STAT_OK;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            rr_reg    <= rr_reg + 1'b1;
                            state_reg <= S_CP_RD;
                        end
                    end
                    else
                    begin
                        cc_reg    <= cc_reg + 1'b1;
                        state_reg <= S_CP_RD;
                    end
                end

                // hand the result to the output register
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= res_q_reg;
                        m_tuser_reg  <= res_st_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

### sim/tb_adaptive_process_noise_estimator_top.sv
`timescale 1ns / 100ps

typedef struct {
    logic signed [31:0] q_entry;
    logic [1:0]         status;
} noise_result_t;

class noise_scoreboard;
    // copy of the block state
    int     products[16][4][4];
    int     count;
    int     head;
    int     delta[4];
    int     staged_post[4][4];
    int     staged_trans[4][4];
    int     cur_post[4][4];
    int     prop_post[4][4];
    int     init_cov[4][4];
    int     offset[4][4];
    int     wlen;
    int     diag;
    longint decay;
    longint scale;
    bit     sat_seen;

    noise_result_t expected_results[$];
    int            mismatches;

    function new();
        for (int r = 0; r < 4; r++)
        begin
            delta[r] = 0;
            for (int c = 0; c < 4; c++)
            begin
                staged_post[r][c]  = 0;
                staged_trans[r][c] = 0;
                cur_post[r][c]     = 0;
                prop_post[r][c]    = 0;
                offset[r][c]       = 0;
                init_cov[r][c]     = (r == c) ? 65536 : 0;
                for (int s = 0; s < 16; s++)
                    products[s][r][c] = 0;
            end
        end
        count = 0;
        head = 0;
        wlen = 16;
        diag = 1;
        decay = 65536;
        scale = 4096;
        mismatches = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [16:0] data);
        case (idx)
            apne_pkg::CFG_WLEN:  wlen = data[4:0];
            apne_pkg::CFG_DIAG:  diag = data[0];
            apne_pkg::CFG_DECAY: decay = (data > 65536) ? 65536 : data;
            apne_pkg::CFG_SCALE: scale = (data > 65536) ? 65536 : data;
            default: ;
        endcase
    endfunction

    function int clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            sat_seen = 1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat_seen = 1;
            return 32'h80000000;
        end
        return int'(v);
    endfunction

    // q16 product rounded half up
    function longint qmul(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function int eff_len();
        if (wlen < 1)
            return 1;
        if (wlen > 16)
            return 16;
        return wlen;
    endfunction

    function logic [1:0] commit_step(int dt);
        int     tmp[4][4];
        longint s;
        if (dt == 0)
            return apne_pkg::STAT_ZERO_DT;
        sat_seen = 0;
        // outer product over dt, truncated
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                products[head][r][c] = clip32((longint'(delta[r]) * delta[c]) / dt);
        head = (head + 1) % 16;
        count = (count + 1 > eff_len()) ? eff_len() : count + 1;
        // propagate old posterior through F
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                s = 0;
                for (int k = 0; k < 4; k++)
                    s += qmul(staged_trans[r][k], cur_post[k][c]);
                tmp[r][c] = clip32(s);
            end
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                s = 0;
                for (int k = 0; k < 4; k++)
                    s += qmul(tmp[r][k], staged_trans[c][k]);
                prop_post[r][c] = clip32(s);
            end
        cur_post = staged_post;
        return sat_seen ? apne_pkg::STAT_SAT : apne_pkg::STAT_OK;
    endfunction

    function noise_result_t query_entry(int r, int c);
        noise_result_t res;
        longint        w;
        longint        acc;
        longint        adapt;
        longint        num;
        longint        den;
        longint        quo;
        int            n;
        int            l;
        l = eff_len();
        n = (count < l) ? count : l;
        w = scale;
        acc = 0;
        // decay-weighted window sum, newest first
        for (int i = 0; i < n; i++)
        begin
            acc += qmul(w, products[(head + 15 - i) % 16][r][c]);
            w = (w * decay + 32768) >>> 16;
        end
        adapt = acc + cur_post[r][c] + prop_post[r][c] + offset[r][c];
        if (diag != 0 && r != c)
            adapt = 0;
        // blend with the initial covariance by fill ratio
        num = adapt * n + longint'(init_cov[r][c]) * (l - n);
        num = 2 * num + l;
        den = 2 * l;
        quo = num / den;
        if ((num % den) != 0 && num < 0)
            quo--;
        sat_seen = 0;
        res.q_entry = clip32(quo);
        res.status = sat_seen ? apne_pkg::STAT_SAT : apne_pkg::STAT_OK;
        return res;
    endfunction

    // predict the result of one accepted input beat
    function void note_item(logic [2:0] fn, logic [1:0] r, logic [1:0] c, logic [31:0] v);
        noise_result_t res;
        res.q_entry = 0;
        res.status = apne_pkg::STAT_OK;
        case (fn)
            apne_pkg::F_DX:     delta[r] = v;
            apne_pkg::F_POST:   staged_post[r][c] = v;
            apne_pkg::F_TRANS:  staged_trans[r][c] = v;
            apne_pkg::F_COMMIT: res.status = commit_step(v);
            apne_pkg::F_QUERY:  res = query_entry(int'(r), int'(c));
            apne_pkg::F_WRESET:
            begin
                count = 0;
                head = 0;
            end
            apne_pkg::F_INIT:   init_cov[r][c] = v;
            default:            offset[r][c] = v;
        endcase
        expected_results.push_back(res);
    endfunction

    function void check_result(logic [31:0] q, logic [1:0] st);
        noise_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat q=%h status=%0d", q, st);
            return;
        end
        want = expected_results.pop_front();
        if (want.q_entry !== q || want.status !== st)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected q=%h status=%0d, got q=%h status=%0d",
                         want.q_entry, want.status, q, st);
        end
    endfunction
endclass

module tb_adaptive_process_noise_estimator_top;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [16:0] cfg_data;

    noise_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              sent;

    adaptive_process_noise_estimator_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // result checking
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);

    // overall time limit
    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // one input beat, called at a falling edge and returning at one
    task automatic send_item(logic [2:0] fn, logic [1:0] r, logic [1:0] c, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'b0, v, c, r};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(fn, r, c, v);
        sent++;
        @(negedge clk);
    endtask

    // one register write, after which cfg_valid is dropped before the task returns
    task automatic write_cfg(logic [3:0] idx, logic [16:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(99);
        if (k < 3)
            return 32'h7fffffff;
        if (k < 6)
            return 32'h80000000;
        if (k < 8)
            return 32'h0;
        if (k < 16)
            return $urandom();
        return $urandom_range(262144) - 131072;
    endfunction

    function automatic logic [31:0] pick_dt();
        int k;
        k = $urandom_range(99);
        if (k < 5)
            return 32'h0;
        if (k < 10)
            return $urandom();
        if (k < 15)
            return 32'hffffffff - $urandom_range(3);
        return $urandom_range(200000, 1);
    endfunction

    // well-formed filter step: loads, commit, queries
    task automatic filter_step();
        int loads;
        for (int r = 0; r < 4; r++)
            send_item(apne_pkg::F_DX, 2'(r), 2'($urandom_range(3)), pick_value());
        loads = $urandom_range(5);
        for (int i = 0; i < loads; i++)
            send_item($urandom_range(1) ? apne_pkg::F_POST : apne_pkg::F_TRANS,
                      2'($urandom_range(3)), 2'($urandom_range(3)), pick_value());
        send_item(apne_pkg::F_COMMIT, 2'($urandom_range(3)), 2'($urandom_range(3)), pick_dt());
        loads = $urandom_range(3, 1);
        for (int i = 0; i < loads; i++)
            send_item(apne_pkg::F_QUERY, 2'($urandom_range(3)), 2'($urandom_range(3)),
                      $urandom());
    endtask

    task automatic random_item();
        send_item(3'($urandom_range(7)), 2'($urandom_range(3)), 2'($urandom_range(3)),
                  pick_value());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values written back explicitly
        write_cfg(apne_pkg::CFG_WLEN, 17'd16);
        write_cfg(apne_pkg::CFG_DIAG, 17'd1);
        write_cfg(apne_pkg::CFG_DECAY, 17'd65536);
        write_cfg(apne_pkg::CFG_SCALE, 17'd4096);

        // directed: empty window, every function, extremes, zero dt, saturation
        send_item(apne_pkg::F_QUERY, 2'd0, 2'd0, 32'h0);
        send_item(apne_pkg::F_QUERY, 2'd3, 2'd1, 32'h0);
        send_item(apne_pkg::F_DX, 2'd0, 2'd0, 32'h7fffffff);
        send_item(apne_pkg::F_DX, 2'd1, 2'd3, 32'h80000000);
        send_item(apne_pkg::F_DX, 2'd2, 2'd0, 32'h00010000);
        send_item(apne_pkg::F_DX, 2'd3, 2'd0, 32'hffff0000);
        send_item(apne_pkg::F_TRANS, 2'd0, 2'd0, 32'h00010000);
        send_item(apne_pkg::F_TRANS, 2'd3, 2'd3, 32'h7fffffff);
        send_item(apne_pkg::F_POST, 2'd3, 2'd3, 32'h80000000);
        send_item(apne_pkg::F_POST, 2'd0, 2'd1, 32'h00020000);
        send_item(apne_pkg::F_COMMIT, 2'd0, 2'd0, 32'h0);
        send_item(apne_pkg::F_COMMIT, 2'd0, 2'd0, 32'h1);
        send_item(apne_pkg::F_COMMIT, 2'd0, 2'd0, 32'hffffffff);
        send_item(apne_pkg::F_INIT, 2'd1, 2'd1, 32'h7fffffff);
        send_item(apne_pkg::F_OFFSET, 2'd1, 2'd1, 32'h80000000);
        send_item(apne_pkg::F_QUERY, 2'd0, 2'd0, 32'h0);
        send_item(apne_pkg::F_QUERY, 2'd1, 2'd1, 32'h0);
        send_item(apne_pkg::F_QUERY, 2'd0, 2'd1, 32'h0);
        send_item(apne_pkg::F_QUERY, 2'd3, 2'd3, 32'h0);
        send_item(apne_pkg::F_WRESET, 2'd0, 2'd0, 32'h0);
        send_item(apne_pkg::F_QUERY, 2'd2, 2'd2, 32'h0);
        send_item(apne_pkg::F_OFFSET, 2'd1, 2'd1, 32'h0);
        send_item(apne_pkg::F_INIT, 2'd1, 2'd1, 32'h00010000);

        // random phases, each with its own idling and settings
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: ;
                1:
                begin
                    write_cfg(apne_pkg::CFG_WLEN, 17'd1);
                    write_cfg(apne_pkg::CFG_DIAG, 17'd0);
                    write_cfg(apne_pkg::CFG_DECAY, 17'd0);
                    write_cfg(apne_pkg::CFG_SCALE, 17'd65536);
                end
                2:
                begin
                    write_cfg(apne_pkg::CFG_WLEN, 17'd31);
                    write_cfg(apne_pkg::CFG_DECAY, 17'h1ffff);
                    write_cfg(apne_pkg::CFG_SCALE, 17'h1ffff);
                    write_cfg(4'd9, 17'd5);
                end
                default:
                begin
                    write_cfg(apne_pkg::CFG_WLEN, 17'd0);
                    write_cfg(apne_pkg::CFG_DIAG, 17'd1);
                    write_cfg(apne_pkg::CFG_DECAY, 17'($urandom_range(65536)));
                    write_cfg(apne_pkg::CFG_SCALE, 17'($urandom_range(65536)));
                end
            endcase
            send_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 23 : 0;
            recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 23 : 0;
            while (sent < 23 + 225 * (phase + 1))
            begin
                if ($urandom_range(9) < 8)
                    filter_step();
                else if ($urandom_range(3) == 0)
                    send_item(apne_pkg::F_WRESET, 2'($urandom_range(3)),
                              2'($urandom_range(3)), pick_value());
                else
                    random_item();
                // occasional window shrink mid-run is left to the phase settings
            end
        end

        drain();
        repeat (100) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
